// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the checker file res_chk.sv
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define RES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define RES_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/res_pkg.sv =====
// shared types, sizes and the sort order for record_exchange_sort
// no dependencies
`default_nettype none

package res_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int ADDR_W      = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int COUNT_W     = $clog2(MAX_RECORDS + 1);
  localparam int FIELD_W     = 16;
  localparam int REC_W       = 3 * FIELD_W;

  typedef struct packed {
    logic [FIELD_W-1:0] tag;
    logic [FIELD_W-1:0] roll;
    logic [FIELD_W-1:0] score;
  } record_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    record_t           wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // b must be placed before a: higher score, or equal score and lower roll
  function automatic logic goes_before(record_t b, record_t a);
    return (b.score > a.score) || ((b.score == a.score) && (b.roll < a.roll));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/res_ram.sv =====
// generic single-clock ram, one write and one registered read port
// no dependencies
`default_nettype none

module res_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/res_ctrl.sv =====
// load, exchange sort and readout sequencer around the record ram
// depends on res_pkg
`default_nettype none

module res_ctrl
  import res_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [FIELD_W-1:0] record_tag,
  input  wire logic [FIELD_W-1:0] roll_number,
  input  wire logic [FIELD_W-1:0] score,
  input  wire logic               is_last_record,
  input  wire record_t            rdata,
  output mem_req_t                mem_req,
  output logic                    busy,
  output logic                    strobe,
  output logic                    out_last,
  output logic                    overflowed
);

  typedef enum logic [2:0] {
    S_LOAD, S_RD_I, S_GET_I, S_SCAN, S_WR_I, S_OUT
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] n;
  logic               ovf;
  logic [ADDR_W-1:0]  i;
  logic [ADDR_W-1:0]  j;
  logic [ADDR_W-1:0]  k;
  record_t            cur;

  logic               accept;
  logic               room;
  logic [COUNT_W-1:0] n_next;
  logic               swap;

  assign busy   = (state != S_LOAD);
  assign accept = start && !busy;
  assign room   = (count < COUNT_W'(MAX_RECORDS));
  assign n_next = room ? (count + COUNT_W'(1)) : COUNT_W'(MAX_RECORDS);
  assign swap   = goes_before(rdata, cur);

  always_comb begin
    mem_req       = '0;
    mem_req.wdata = cur;
    unique case (state)
      S_LOAD: begin
        if (accept && room) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = count[ADDR_W-1:0];
          mem_req.wdata = '{tag: record_tag, roll: roll_number, score: score};
        end
      end
      S_RD_I:  mem_req.raddr = i;
      S_GET_I: mem_req.raddr = i + ADDR_W'(1);
      S_SCAN: begin
        // next slot is fetched while the current one is compared
        mem_req.raddr = j + ADDR_W'(1);
        if (swap) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = j;
        end
      end
      S_WR_I: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = i;
        mem_req.raddr = i + ADDR_W'(1);
      end
      S_OUT:   mem_req.raddr = k;
      default: mem_req.raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      count      <= '0;
      ovf        <= 1'b0;
      strobe     <= 1'b0;
      out_last   <= 1'b0;
      overflowed <= 1'b0;
    end else begin
      // a result leaves in the cycle after its slot is addressed
      strobe   <= (state == S_OUT);
      out_last <= (state == S_OUT) && (COUNT_W'(k) == n - COUNT_W'(1));
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            count <= n_next;
            if (!room) begin
              ovf <= 1'b1;
            end
            if (is_last_record) begin
              n <= n_next;
              i <= '0;
              k <= '0;
              state <= (n_next == COUNT_W'(1)) ? S_OUT : S_RD_I;
            end
          end
        end
        S_RD_I: state <= S_GET_I;
        S_GET_I: begin
          cur   <= rdata;
          j     <= i + ADDR_W'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (swap) begin
            cur <= rdata;
          end
          if (COUNT_W'(j) == n - COUNT_W'(1)) begin
            state <= S_WR_I;
          end else begin
            j <= j + ADDR_W'(1);
          end
        end
        S_WR_I: begin
          if (COUNT_W'(i) + COUNT_W'(2) == n) begin
            k     <= '0;
            state <= S_OUT;
          end else begin
            i     <= i + ADDR_W'(1);
            state <= S_GET_I;
          end
        end
        S_OUT: begin
          overflowed <= ovf;
          if (COUNT_W'(k) == n - COUNT_W'(1)) begin
            count <= '0;
            ovf   <= 1'b0;
            state <= S_LOAD;
          end else begin
            k <= k + ADDR_W'(1);
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/record_exchange_sort.sv =====
// loading: one record per cycle; the last item of a set starts the sort
// sort: n*(n-1)/2 + 2*n - 1 cycles after the last item for n > 1 records, none for one
// output: n results on consecutive cycles, the first in the second cycle after the sort
// a new set may be loaded from the cycle that carries the final result; no result stall
// rst (synchronous) empties the set and clears the overflow flag; ram contents stay
// top level: ties the sequencer to the record ram, depends on res_pkg
`default_nettype none

module record_exchange_sort
  import res_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [FIELD_W-1:0] record_tag,
  input  wire logic [FIELD_W-1:0] roll_number,
  input  wire logic [FIELD_W-1:0] score,
  input  wire logic               is_last_record,
  output logic                    strobe,
  output logic      [FIELD_W-1:0] out_tag,
  output logic      [FIELD_W-1:0] out_roll,
  output logic      [FIELD_W-1:0] out_score,
  output logic                    out_last,
  output logic                    overflowed
);

  mem_req_t mem_req;
  record_t  rdata;

  res_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  res_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .record_tag     (record_tag),
    .roll_number    (roll_number),
    .score          (score),
    .is_last_record (is_last_record),
    .rdata          (rdata),
    .mem_req        (mem_req),
    .busy           (busy),
    .strobe         (strobe),
    .out_last       (out_last),
    .overflowed     (overflowed)
  );

  // ram read data is the output register for each result
  assign out_tag   = rdata.tag;
  assign out_roll  = rdata.roll;
  assign out_score = rdata.score;

endmodule

`default_nettype wire

// ===== hw/rtl/res_chk.sv =====
// port-level checks for record_exchange_sort, attached by bind
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module res_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic is_last_record,
  input wire logic strobe,
  input wire logic out_last
);

  `RES_ASSERT_ALWAYS(a_no_strobe_after_rst, rst |=> !strobe, "result right after reset")
  `RES_ASSERT(a_last_has_strobe, out_last |-> strobe, "out_last without a result")
  `RES_ASSERT(a_run_contiguous, (strobe && !out_last) |=> strobe, "gap in result run")
  `RES_ASSERT(a_idle_at_run_end, (strobe && out_last) |-> !busy, "busy at end of run")
  `RES_ASSERT(a_busy_after_last, (start && !busy && is_last_record) |=> busy, "not busy")

endmodule

bind record_exchange_sort res_chk u_chk (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .is_last_record (is_last_record),
  .strobe         (strobe),
  .out_last       (out_last)
);

`default_nettype wire
